FILE: sv/echo_state_reservoir_update_top_assert.svh
// Assertion macros for the reservoir update block.
`ifndef ECHO_STATE_RESERVOIR_UPDATE_TOP_ASSERT_SVH
`define ECHO_STATE_RESERVOIR_UPDATE_TOP_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define ESR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ESR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/esr_pkg.sv
// Shared constants and the tanh table for the reservoir update block.
package esr_pkg;
  localparam int MaxNodes  = 32;
  localparam int IdxW      = $clog2(MaxNodes);
  localparam int ValueBits = 16;
  localparam int AccW      = 2 * ValueBits + IdxW + 1;
  localparam int FracBits  = 12;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_STATE  = 2'd1;
  localparam logic [1:0] KIND_DRIVE  = 2'd2;

  localparam logic CFG_SIZE    = 1'b0;
  localparam logic CFG_SQUARES = 1'b1;

  function automatic logic signed [13:0] tanh_point(input logic [4:0] k);
    logic signed [13:0] r;
    unique case (k)
      5'd0: r = -14'sd4093;  5'd1: r = -14'sd4089;  5'd2: r = -14'sd4076;
      5'd3: r = -14'sd4041;  5'd4: r = -14'sd3949;  5'd5: r = -14'sd3707;
      5'd6: r = -14'sd3119;  5'd7: r = -14'sd1893;  5'd8: r = 14'sd0;
      5'd9: r = 14'sd1893;   5'd10: r = 14'sd3119;  5'd11: r = 14'sd3707;
      5'd12: r = 14'sd3949;  5'd13: r = 14'sd4041;  5'd14: r = 14'sd4076;
      5'd15: r = 14'sd4089;  5'd16: r = 14'sd4093;
      default: r = 14'sd0;
    endcase
    return r;
  endfunction
endpackage

FILE: sv/esr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module esr_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/echo_state_reservoir_update_top.sv
// Top level of the echo state reservoir update block.
// Input stream in_*: tdata carries kind, row_index, col_index, value; tlast is
// end_of_vector. Weight, state and plain drive transactions are written as they
// are accepted. A drive transaction with tlast runs a time step when the size is
// not zero. For each element i < n one shared multiplier first walks row i of
// the weight RAM, one product per cycle, then a drain step adds the last
// product. The activation steps follow: clamp, segment lookup, then
// interpolation on the same multiplier. A last step forms the square on it and
// loads the output register. The single multiplier and the single weight RAM
// read port are shared, so elements are computed one after another, and a copy
// step ends the time step. in_tready is low during a step. New states are kept
// in a shadow buffer and copied into the state vector when the step ends, so
// every element sees the old state. Results leave through one output register;
// if it still holds a result and out_tready is low, the sequencer waits in its
// output state with that result held. Reset (rst_n low, synchronous) clears the
// state vector to zero, size to 32 and squares_enable to 1; weights and drive
// values are undefined until written. cfg_* writes register 0 (size, saturated
// to 32 when larger) or register 1 (squares_enable).
module echo_state_reservoir_update_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // kind[1:0], row_index[6:2], col_index[11:7], value[27:12]
  input  logic        in_tlast,   // end_of_vector
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // element_index[4:0], state_value[18:5], square_value[31:19]
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata
);
  localparam int N  = esr_pkg::MaxNodes;
  localparam int IW = esr_pkg::IdxW;
  localparam int VB = esr_pkg::ValueBits;
  localparam int AW = esr_pkg::AccW;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN, S_PRE, S_SEG, S_INT, S_OUT, S_COPY
  } state_t;
  state_t st_r;

  logic [1:0]          kind;
  logic [IW-1:0]       row, col;
  logic signed [VB-1:0] val;
  assign kind = in_tdata[1:0];
  assign row  = in_tdata[6:2];
  assign col  = in_tdata[11:7];
  assign val  = in_tdata[27:12];

  logic [6:0] size_r;
  logic       sq_en_r;
  logic [IW:0] n_eff;
  assign n_eff = (size_r > 7'(N)) ? (IW+1)'(N) : size_r[IW:0];

  logic signed [VB-1:0] x_r   [N];
  logic signed [13:0]   new_r [N];
  logic signed [VB-1:0] d_r   [N];

  logic [IW:0] i_r, j_r;
  logic signed [AW-1:0] acc_r;
  logic [1:0] pend_r;   // RAM reads in flight
  logic signed [13:0] y_r;
  logic signed [VB-1:0] jx_r;
  logic signed [VB-1:0] pre_r;
  logic signed [13:0]   lo_r, dif_r;
  logic [10:0]          frac_r;
  logic                 satp_r, satn_r;

  logic accept;
  assign in_tready = (st_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  logic wr_w;
  logic [2*IW-1:0] raddr;
  logic [VB-1:0] rdata;
  assign wr_w = accept && (kind == esr_pkg::KIND_WEIGHT);
  assign raddr = {i_r[IW-1:0], j_r[IW-1:0]};
  esr_ram #(.Width(VB), .Depth(N*N)) u_wram (
    .clk(clk), .we(wr_w), .waddr({row, col}), .wdata(val),
    .raddr(raddr), .rdata(rdata)
  );

  // Single multiplier: weight x delayed state during the row walk, slope x
  // fraction while interpolating, state x state while the result is loaded.
  logic signed [VB-1:0]   mul_a, mul_b;
  logic signed [2*VB-1:0] prod;
  always_comb begin
    unique case (st_r)
      S_INT: begin
        mul_a = VB'(dif_r);
        mul_b = VB'({1'b0, frac_r});
      end
      S_OUT: begin
        mul_a = VB'(y_r);
        mul_b = VB'(y_r);
      end
      default: begin
        mul_a = $signed(rdata);
        mul_b = jx_r;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Pre-activation: floor(acc/4096) + drive, clamped.
  logic signed [AW-1:0] pre;
  logic signed [VB-1:0] pre_c;
  logic signed [VB+2:0] off;
  logic [3:0]  seg;
  logic [10:0] frac;
  logic signed [13:0] lo, hi;
  logic signed [13:0] tanh_v;
  always_comb begin
    pre = (acc_r >>> esr_pkg::FracBits) + AW'(d_r[i_r[IW-1:0]]);
    if (pre > AW'((1 <<< (VB-1)) - 1)) pre_c = {1'b0, {(VB-1){1'b1}}};
    else if (pre < -(AW'(1) <<< (VB-1))) pre_c = {1'b1, {(VB-1){1'b0}}};
    else pre_c = pre[VB-1:0];
    off   = (VB+3)'(pre_r) + (VB+3)'(16384);
    seg   = off[14:11];
    frac  = off[10:0];
    lo    = esr_pkg::tanh_point({1'b0, seg});
    hi    = esr_pkg::tanh_point(5'({1'b0, seg}) + 5'd1);
    if (satp_r) tanh_v = 14'sd4096;
    else if (satn_r) tanh_v = -14'sd4096;
    else tanh_v = lo_r + 14'(prod >>> 11);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; size_r <= 7'd32; sq_en_r <= 1'b1;
      out_tvalid <= 1'b0; out_tlast <= 1'b0;
      i_r <= '0; j_r <= '0; pend_r <= '0;
      for (int k = 0; k < N; k++) x_r[k] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          esr_pkg::CFG_SIZE:    size_r <= {1'b0, cfg_wdata};
          esr_pkg::CFG_SQUARES: sq_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (accept) begin
            if (kind == esr_pkg::KIND_STATE) x_r[row] <= val;
            if (kind == esr_pkg::KIND_DRIVE) begin
              d_r[row] <= val;
              if (in_tlast && n_eff != 0) begin
                st_r <= S_MAC; i_r <= '0; j_r <= '0; acc_r <= '0; pend_r <= '0;
              end
            end
          end
        end
        S_MAC: begin
          // issue read j, accumulate read j-1
          jx_r <= x_r[j_r[IW-1:0]];
          if (pend_r != 0) acc_r <= acc_r + AW'(prod);
          pend_r <= 2'd1;
          if (j_r + 1'b1 == n_eff) st_r <= S_DRAIN;
          else j_r <= j_r + 1'b1;
        end
        S_DRAIN: begin
          acc_r <= acc_r + AW'(prod);
          st_r <= S_PRE;
        end
        S_PRE: begin
          pre_r <= pre_c;
          st_r <= S_SEG;
        end
        S_SEG: begin
          lo_r   <= lo;
          dif_r  <= hi - lo;
          frac_r <= frac;
          satp_r <= (pre_r >= 16'sd16384);
          satn_r <= (pre_r < -16'sd16384);
          st_r   <= S_INT;
        end
        S_INT: begin
          y_r <= tanh_v;
          new_r[i_r[IW-1:0]] <= tanh_v;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tdata <= {(sq_en_r ? prod[24:12] : 13'd0), y_r, i_r[IW-1:0]};
            out_tlast <= (i_r + 1'b1 == n_eff);
            if (i_r + 1'b1 == n_eff) begin
              st_r <= S_COPY; j_r <= '0;
            end else begin
              i_r <= i_r + 1'b1; j_r <= '0; acc_r <= '0; pend_r <= '0;
              st_r <= S_MAC;
            end
          end
        end
        S_COPY: begin
          for (int k = 0; k < N; k++)
            if (k < int'(n_eff)) x_r[k] <= VB'(new_r[k]);
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (out_tvalid && out_tready && !(st_r == S_OUT)) out_tvalid <= 1'b0;
    end
  end

  `include "echo_state_reservoir_update_top_assert.svh"
  `ESR_ASSERT_IMP(a_busy_not_ready, st_r != S_IDLE, !in_tready)
  `ESR_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ESR_ASSERT_IMP(a_idx_range, out_tvalid, out_tdata[IW-1:0] < n_eff[IW-1:0] || n_eff == (IW+1)'(N))
endmodule

FILE: dv/echo_state_reservoir_update_checker.sv
// Checker for the reservoir update block: predicts each time step and compares results.
module echo_state_reservoir_update_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          steps_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]         idx;
    logic signed [13:0] st;
    logic [12:0]        sq;
    logic               last;
  } node_result_t;

  localparam int TanhKnots [17] = '{-4093, -4089, -4076, -4041, -3949, -3707, -3119,
                                    -1893, 0, 1893, 3119, 3707, 3949, 4041, 4076,
                                    4089, 4093};

  logic signed [15:0] weights [esr_pkg::MaxNodes][esr_pkg::MaxNodes];
  logic signed [15:0] node_state [esr_pkg::MaxNodes];
  logic signed [15:0] drive [esr_pkg::MaxNodes];
  logic [5:0]         size_reg;
  logic               squares_on;
  node_result_t       node_results_q [$];

  function automatic int tanh_approx(longint x);
    int off, seg, frac, lo, hi;
    if (x >= 16384) return 4096;
    if (x < -16384) return -4096;
    off  = int'(x) + 16384;
    seg  = (off >> 11) & 15;
    frac = off & 2047;
    lo   = TanhKnots[seg];
    hi   = TanhKnots[seg + 1];
    return lo + (((hi - lo) * frac) >> 11);
  endfunction

  // All new elements come from the old state, then are committed together.
  function automatic void advance_reservoir();
    int           n;
    longint       acc, pre;
    int           fresh [esr_pkg::MaxNodes];
    node_result_t r;
    n = (size_reg > esr_pkg::MaxNodes) ? esr_pkg::MaxNodes : int'(size_reg);
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) acc += longint'(weights[i][j]) * longint'(node_state[j]);
      pre = (acc >>> 12) + longint'(drive[i]);
      if (pre > 32767) pre = 32767;
      if (pre < -32768) pre = -32768;
      fresh[i] = tanh_approx(pre);
    end
    for (int i = 0; i < n; i++) begin
      node_state[i] = 16'(fresh[i]);
      r.idx  = 5'(i);
      r.st   = 14'(fresh[i]);
      r.sq   = squares_on ? 13'((fresh[i] * fresh[i]) >> 12) : 13'd0;
      r.last = (i + 1 == n);
      node_results_q.push_back(r);
    end
    steps_seen++;
  endfunction

  always @(posedge clk) begin
    node_result_t got, want;
    logic [1:0]   kind;
    logic [4:0]   row, col;
    if (!rst_n) begin
      foreach (node_state[i]) node_state[i] = '0;
      foreach (drive[i]) drive[i] = '0;
      foreach (weights[i, j]) weights[i][j] = '0;
      size_reg   = 6'd32;
      squares_on = 1'b1;
      node_results_q.delete();
      errors = 0;
      results_seen = 0;
      steps_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == esr_pkg::CFG_SIZE) size_reg = cfg_wdata;
        else squares_on = cfg_wdata[0];
      end
      if (in_tvalid && in_tready) begin
        kind = in_tdata[1:0];
        row  = in_tdata[6:2];
        col  = in_tdata[11:7];
        case (kind)
          esr_pkg::KIND_WEIGHT: weights[row][col] = in_tdata[27:12];
          esr_pkg::KIND_STATE:  node_state[row] = in_tdata[27:12];
          esr_pkg::KIND_DRIVE: begin
            drive[row] = in_tdata[27:12];
            if (in_tlast) advance_reservoir();
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[4:0], out_tdata[18:5], out_tdata[31:19], out_tlast};
        results_seen++;
        if (node_results_q.size() == 0) begin
          $display("%0t: unexpected result transaction idx=%0d state=%0d sq=%0d last=%0b",
                   $time, got.idx, got.st, got.sq, got.last);
          errors++;
        end else begin
          want = node_results_q.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t: element_index expected %0d actual %0d", $time, want.idx, got.idx);
            errors++;
          end
          if (got.st !== want.st) begin
            $display("%0t: state_value[%0d] expected %0d actual %0d",
                     $time, want.idx, want.st, got.st);
            errors++;
          end
          if (got.sq !== want.sq) begin
            $display("%0t: square_value[%0d] expected %0d actual %0d",
                     $time, want.idx, want.sq, got.sq);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last[%0d] expected %0b actual %0b",
                     $time, want.idx, want.last, got.last);
            errors++;
          end
        end
      end
    end
    pending = node_results_q.size();
  end
endmodule

FILE: dv/echo_state_reservoir_update_top_test.sv
// Testbench top for the reservoir update block: stimulus, flow control and verdict.
module echo_state_reservoir_update_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = esr_pkg::CFG_SIZE;
  logic [5:0]  cfg_wdata = '0;
  int          errors, pending, results_seen, steps_seen;

  bit          weight_set [esr_pkg::MaxNodes][esr_pkg::MaxNodes];
  bit          drive_set [esr_pkg::MaxNodes];
  int          burst_left = 0;
  int          items_sent = 0;
  int          n_now = 32;

  echo_state_reservoir_update_top dut (.*);

  echo_state_reservoir_update_checker checker_i (.*);

  always #5 clk = ~clk;

  // Receiver: alternates always-ready, random, and long-stall stretches.
  int stall_mode = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic push(input logic [1:0] kind, input int row, input int col,
                      input logic [15:0] val, input logic eov);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, val, 5'(col), 5'(row), kind};
    in_tlast  <= eov;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (kind == esr_pkg::KIND_WEIGHT) weight_set[row][col] = 1'b1;
    if (kind == esr_pkg::KIND_DRIVE) drive_set[row] = 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every result is in and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic addr, input logic [5:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == esr_pkg::CFG_SIZE)
      n_now = (data > esr_pkg::MaxNodes) ? esr_pkg::MaxNodes : int'(data);
  endtask

  // Any weight or drive the step will read must have been written first.
  task automatic fill_unwritten();
    for (int i = 0; i < n_now; i++) begin
      for (int j = 0; j < n_now; j++)
        if (!weight_set[i][j]) push(esr_pkg::KIND_WEIGHT, i, j, pick_value(), 1'b0);
      if (!drive_set[i]) push(esr_pkg::KIND_DRIVE, i, 0, pick_value(), 1'b0);
    end
  endtask

  task automatic time_step(input logic [15:0] last_val);
    fill_unwritten();
    push(esr_pkg::KIND_DRIVE, $urandom_range(0, 31), $urandom_range(0, 31), last_val, 1'b1);
  endtask

  task automatic random_step();
    int k;
    k = $urandom_range(0, 6);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push(esr_pkg::KIND_WEIGHT, $urandom_range(0, 31), $urandom_range(0, 31),
                      pick_value(), $urandom_range(0, 1));
        3: push(esr_pkg::KIND_STATE, $urandom_range(0, 31), $urandom_range(0, 31),
                pick_value(), $urandom_range(0, 1));
        4: push(KIND_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                16'($urandom), $urandom_range(0, 1));
        default: push(esr_pkg::KIND_DRIVE, $urandom_range(0, 31), $urandom_range(0, 31),
                      pick_value(), 1'b0);
      endcase
    end
    time_step(pick_value());
  endtask

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small reservoir with extreme weights, states and drives.
    cfg_write(esr_pkg::CFG_SIZE, 6'd4);
    cfg_write(esr_pkg::CFG_SQUARES, 6'd1);
    push(esr_pkg::KIND_WEIGHT, 0, 0, 16'h8000, 1'b0);
    push(esr_pkg::KIND_WEIGHT, 0, 1, 16'h7fff, 1'b1);
    push(esr_pkg::KIND_WEIGHT, 1, 0, 16'h7fff, 1'b0);
    push(esr_pkg::KIND_WEIGHT, 31, 31, 16'hffff, 1'b0);
    push(esr_pkg::KIND_STATE, 0, 31, 16'h7fff, 1'b1);
    push(esr_pkg::KIND_STATE, 1, 0, 16'h8000, 1'b0);
    push(esr_pkg::KIND_STATE, 31, 0, 16'h1000, 1'b0);
    push(KIND_UNUSED, 0, 0, 16'h1234, 1'b1);
    push(esr_pkg::KIND_DRIVE, 2, 0, 16'h7fff, 1'b0);
    push(esr_pkg::KIND_DRIVE, 3, 0, 16'h8000, 1'b0);
    time_step(16'h0000);
    time_step(16'hc000);
    cfg_write(esr_pkg::CFG_SQUARES, 6'd0);
    time_step(16'h4000);
    cfg_write(esr_pkg::CFG_SIZE, 6'd0);
    push(esr_pkg::KIND_DRIVE, 0, 0, 16'h0100, 1'b1);
    cfg_write(esr_pkg::CFG_SIZE, 6'd1);
    cfg_write(esr_pkg::CFG_SQUARES, 6'd1);
    time_step(16'h3fff);

    // Random phases over small reservoir sizes.
    while (items_sent < 180) begin
      cfg_write(esr_pkg::CFG_SIZE, 6'($urandom_range(0, 6)));
      cfg_write(esr_pkg::CFG_SQUARES, 6'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) random_step();
    end

    drain();
    $display("Covered %0d input transactions and %0d time steps, %0d result transactions.",
             items_sent, steps_seen, results_seen);
    $display("Sizes 0 to 6, squares on and off, clamped sums, unused kinds, stray end marks.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/esr_pkg.sv
sv/esr_ram.sv
sv/echo_state_reservoir_update_top.sv
dv/echo_state_reservoir_update_checker.sv
dv/echo_state_reservoir_update_top_test.sv
